// ===== sv/qksd_pkg.sv =====
// Shared types and constants for the quad key sort and dedupe block.
// No dependencies; used by every module of the block.
package qksd_pkg;

   localparam int IDX_W  = 16;
   localparam int PAY_W  = 32;
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One canonical record as it travels from the front to the back.
   typedef struct packed {
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
      logic [IDX_W-1:0] third;
      logic [IDX_W-1:0] fourth;
      logic [PAY_W-1:0] pay_a;
      logic [PAY_W-1:0] pay_b;
      logic [PAY_W-1:0] pay_c;
      logic             last;
   } rec_type;

   // One stored entry: sort key followed by payload.
   typedef struct packed {
      logic [4*IDX_W-1:0] key;
      logic [PAY_W-1:0]   pay_a;
      logic [PAY_W-1:0]   pay_b;
      logic [PAY_W-1:0]   pay_c;
   } ent_type;

   // Handshake between the queue and the sorter.
   typedef struct packed {
      logic    valid;
      rec_type rec;
   } qout_type;

endpackage

// ===== sv/quad_key_sort_dedupe.sv =====
// Top level of the quad key sort and dedupe block.
// Depends on qksd_pkg, qksd_front and qksd_back.
//
// Usage:
// A request is taken at a clock edge where start is high and busy is low.
// Each request carries four indices, three payload words and a last flag.
// The front end swaps the index pairs so that the third index is not below
// the first, and parks the record in a two-entry queue; busy is high only
// while that queue is full.
// The back end inserts records into a 64-row memory kept in key order.
// While searching it reads and compares one row at a time, and while
// opening a gap it reads each row and writes it one row up; it takes the
// next record from the queue only once the current one is settled.
// A record whose indices are already stored is dropped, and the earlier
// payload is kept. When the store is full, new records are dropped and
// the overflow flag is raised for the set.
// After the last record, the sorted set is emitted one result per cycle,
// with rsp_valid high for exactly one cycle per result, once the emit
// state has registered the first row. The receiver cannot stall.
// Reset clears the queue, the entry count and the overflow flag.
module quad_key_sort_dedupe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [qksd_pkg::IDX_W-1:0]  req_first_index,
   input  logic [qksd_pkg::IDX_W-1:0]  req_second_index,
   input  logic [qksd_pkg::IDX_W-1:0]  req_third_index,
   input  logic [qksd_pkg::IDX_W-1:0]  req_fourth_index,
   input  logic [qksd_pkg::PAY_W-1:0]  req_payload_a,
   input  logic [qksd_pkg::PAY_W-1:0]  req_payload_b,
   input  logic [qksd_pkg::PAY_W-1:0]  req_payload_c,
   input  logic                        req_last_item,
   output logic                        rsp_valid,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_first,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_second,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_third,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_fourth,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_a,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_b,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_c,
   output logic                        rsp_last_of_run,
   output logic [qksd_pkg::CNT_W-1:0]  rsp_kept_count,
   output logic                        rsp_overflow
);

   qksd_pkg::qout_type q_out;
   logic               q_pop;

   // Request intake and canonical form.
   qksd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_third_index  (req_third_index),
      .req_fourth_index (req_fourth_index),
      .req_payload_a    (req_payload_a),
      .req_payload_b    (req_payload_b),
      .req_payload_c    (req_payload_c),
      .req_last_item    (req_last_item),
      .q_out            (q_out),
      .q_pop            (q_pop)
   );

   // Sorted store and emission.
   qksd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_out             (q_out),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_out_first     (rsp_out_first),
      .rsp_out_second    (rsp_out_second),
      .rsp_out_third     (rsp_out_third),
      .rsp_out_fourth    (rsp_out_fourth),
      .rsp_out_payload_a (rsp_out_payload_a),
      .rsp_out_payload_b (rsp_out_payload_b),
      .rsp_out_payload_c (rsp_out_payload_c),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

// ===== sv/qksd_front.sv =====
// Front end: takes requests, makes each record canonical and queues it.
// Depends on qksd_pkg.
module qksd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [qksd_pkg::IDX_W-1:0] req_first_index,
   input  logic [qksd_pkg::IDX_W-1:0] req_second_index,
   input  logic [qksd_pkg::IDX_W-1:0] req_third_index,
   input  logic [qksd_pkg::IDX_W-1:0] req_fourth_index,
   input  logic [qksd_pkg::PAY_W-1:0] req_payload_a,
   input  logic [qksd_pkg::PAY_W-1:0] req_payload_b,
   input  logic [qksd_pkg::PAY_W-1:0] req_payload_c,
   input  logic                     req_last_item,
   output qksd_pkg::qout_type       q_out,
   input  logic                     q_pop
);

   qksd_pkg::rec_type                 q_ff [qksd_pkg::QUEUE_DEPTH];
   logic [qksd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [qksd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [qksd_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   qksd_pkg::rec_type                 canon;
   logic                              push;

   function automatic logic [qksd_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
      QCNT_ONE = {{(qksd_pkg::QCNT_W-1){1'b0}}, b};
   endfunction

   // Swap the pairs when the third index is below the first.
   always_comb begin
      canon.pay_a = req_payload_a;
      canon.pay_b = req_payload_b;
      canon.pay_c = req_payload_c;
      canon.last  = req_last_item;
      if (req_third_index < req_first_index) begin
         canon.first  = req_third_index;
         canon.second = req_fourth_index;
         canon.third  = req_first_index;
         canon.fourth = req_second_index;
      end else begin
         canon.first  = req_first_index;
         canon.second = req_second_index;
         canon.third  = req_third_index;
         canon.fourth = req_fourth_index;
      end
   end

   assign busy  = (cnt_ff == qksd_pkg::QCNT_W'(qksd_pkg::QUEUE_DEPTH));
   assign push  = start && !busy;
   assign q_out = {(cnt_ff != '0), q_ff[rd_ptr_ff]};

   // Queue pointers and occupancy.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_ONE(push) - QCNT_ONE(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= canon;
      end
   end

endmodule

// ===== sv/qksd_back.sv =====
// Back end: insertion sorter over a record memory, dedupe and set emission.
// Depends on qksd_pkg.
module qksd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  qksd_pkg::qout_type          q_out,
   output logic                        q_pop,
   output logic                        rsp_valid,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_first,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_second,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_third,
   output logic [qksd_pkg::IDX_W-1:0]  rsp_out_fourth,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_a,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_b,
   output logic [qksd_pkg::PAY_W-1:0]  rsp_out_payload_c,
   output logic                        rsp_last_of_run,
   output logic [qksd_pkg::CNT_W-1:0]  rsp_kept_count,
   output logic                        rsp_overflow
);

   localparam int AW = qksd_pkg::ADDR_W;
   localparam int CW = qksd_pkg::CNT_W;
   localparam int IW = qksd_pkg::IDX_W;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SRD   = 9'b000000010,
      ST_SCMP  = 9'b000000100,
      ST_DECIDE = 9'b000001000,
      ST_SHRD  = 9'b000010000,
      ST_SHWR  = 9'b000100000,
      ST_WRITE = 9'b001000000,
      ST_EMIT  = 9'b010000000,
      ST_DRAIN = 9'b100000000
   } state_type;

   qksd_pkg::ent_type   mem [qksd_pkg::DEPTH];
   qksd_pkg::ent_type   rd_ff;
   state_type           state_ff, state_in;
   qksd_pkg::rec_type   cur_ff, cur_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                rv_ff, rv_in;
   logic [CW-1:0]       ridx_ff, ridx_in;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   qksd_pkg::ent_type   wr_data;
   logic [4*IW-1:0]     cur_key;
   state_type           after_rec;

   assign cur_key = {cur_ff.first, cur_ff.second, cur_ff.third, cur_ff.fourth};
   // Once a record is settled, either emit the set or take the next one.
   assign after_rec = cur_ff.last ? ST_EMIT : ST_IDLE;

   // Sequencer: search, shift up and insert or drop, then emit on the last record.
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      rv_in    = 1'b0;
      ridx_in  = ridx_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data.key   = cur_key;
      wr_data.pay_a = cur_ff.pay_a;
      wr_data.pay_b = cur_ff.pay_b;
      wr_data.pay_c = cur_ff.pay_c;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               cur_in   = q_out.rec;
               pos_in   = '0;
               state_in = (count_ff == '0) ? ST_DECIDE : ST_SRD;
            end
         end
         ST_SRD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff[AW-1:0];
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (rd_ff.key == cur_key) begin
               state_in = after_rec;
               pos_in   = '0;
            end else if (rd_ff.key < cur_key) begin
               pos_in   = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 == count_ff) ? ST_DECIDE : ST_SRD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (count_ff == CW'(qksd_pkg::DEPTH)) begin
               ovf_in   = 1'b1;
               pos_in   = '0;
               state_in = after_rec;
            end else begin
               k_in     = count_ff;
               state_in = (count_ff > pos_ff) ? ST_SHRD : ST_WRITE;
            end
         end
         ST_SHRD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(k_ff - 1'b1);
            state_in = ST_SHWR;
         end
         ST_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff[AW-1:0];
            wr_data  = rd_ff;
            k_in     = k_ff - 1'b1;
            state_in = (k_ff - 1'b1 == pos_ff) ? ST_WRITE : ST_SHRD;
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            count_in = count_ff + 1'b1;
            pos_in   = '0;
            state_in = after_rec;
         end
         ST_EMIT: begin
            rd_en   = 1'b1;
            rd_addr = pos_ff[AW-1:0];
            rv_in   = 1'b1;
            ridx_in = pos_ff;
            pos_in  = pos_ff + 1'b1;
            if (pos_ff + 1'b1 == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            count_in = '0;
            ovf_in   = 1'b0;
            pos_in   = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
         k_ff     <= '0;
         rv_ff    <= 1'b0;
         ridx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         k_ff     <= k_in;
         rv_ff    <= rv_in;
         ridx_ff  <= ridx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Record memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Result fields come straight from the read register; flags and count from their own registers.
   assign rsp_valid         = rv_ff;
   assign rsp_out_first     = rd_ff.key[4*IW-1:3*IW];
   assign rsp_out_second    = rd_ff.key[3*IW-1:2*IW];
   assign rsp_out_third     = rd_ff.key[2*IW-1:IW];
   assign rsp_out_fourth    = rd_ff.key[IW-1:0];
   assign rsp_out_payload_a = rd_ff.pay_a;
   assign rsp_out_payload_b = rd_ff.pay_b;
   assign rsp_out_payload_c = rd_ff.pay_c;
   assign rsp_last_of_run   = rv_ff && (ridx_ff + 1'b1 == count_ff);
   assign rsp_kept_count    = count_ff;
   assign rsp_overflow      = ovf_ff;

   // The store never holds more entries than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(qksd_pkg::DEPTH))
      else $error("entry count above store depth");

   // A result is never shown for an empty set.
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_count != '0))
      else $error("result with zero kept count");

   // The final result of a set is followed by a gap and a cleared store.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |=> (!rsp_valid && count_ff == '0))
      else $error("set not closed after its final result");

   // Shifting only runs above the insertion point.
   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHWR) |-> (k_ff > pos_ff))
      else $error("shift below insertion point");

endmodule
